/* rtl/fpa_pkg.sv */
// ============================================================================
// fpa_pkg
// Shared types and constants of the fit-policy unit allocator: field widths,
// operation, status and fit-mode codes, the controller states and the control
// group that drives the hole scanner.
// ============================================================================
package fpa_pkg;

    // Field widths of the request and response transactions.
    localparam int OP_W   = 1;
    localparam int SIZE_W = 11;
    localparam int POS_W  = 10;
    localparam int STAT_W = 2;
    localparam int MODE_W = 2;

    // The unit map is stored 32 units to a RAM word and scanned 8 units at a time.
    localparam int WORD_W      = 32;
    localparam int WORD_SHIFT  = 5;
    localparam int CHUNK_W     = 8;
    localparam int CHUNK_SHIFT = 3;
    localparam int CHUNK_IDX_W = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
    localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FREE  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    // Fit-mode codes; the unused code behaves as first fit.
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_CLOSE,
        S_PICK,
        S_CHECK,
        S_WRITE,
        S_DONE
    } t_state;

    // Control group from the controller to the hole scanner.
    typedef struct packed {
        logic start;
        logic step;
        logic close;
    } t_scan_ctrl;

endpackage

/* rtl/fpa_if.sv */
// ============================================================================
// fpa_if
// Valid/ready channels of the allocator: the request channel carries the
// operation, size and release position, the response channel the status and
// the position.
// ============================================================================
interface fpa_req_if;
    logic                        valid;
    logic                        ready;
    logic [fpa_pkg::OP_W-1:0]    operation;
    logic [fpa_pkg::SIZE_W-1:0]  size_units;
    logic [fpa_pkg::POS_W-1:0]   release_position;

    modport source (
        output valid, operation, size_units, release_position,
        input  ready
    );
    modport sink (
        input  valid, operation, size_units, release_position,
        output ready
    );
endinterface

interface fpa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [fpa_pkg::STAT_W-1:0]  status;
    logic [fpa_pkg::POS_W-1:0]   position;

    modport source (
        output valid, status, position,
        input  ready
    );
    modport sink (
        input  valid, status, position,
        output ready
    );
endinterface

/* rtl/fpa_ram.sv */
// ============================================================================
// fpa_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. The read data holds between reads.
// ============================================================================
module fpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/fpa_run_mask.sv */
// ============================================================================
// fpa_run_mask
// Builds the bit mask of one map word that covers the units of the run
// [lo, hi). Used both to check a release and to set or clear a run.
// ============================================================================
module fpa_run_mask #(
    parameter int LW = 12,
    parameter int AW = 5
) (
    input  logic [LW-1:0]              i_lo,
    input  logic [LW-1:0]              i_hi,
    input  logic [AW-1:0]              i_word,
    output logic [fpa_pkg::WORD_W-1:0] o_mask
);

    // Each bit compares its own unit index against both ends of the run.
    always_comb begin
        logic [LW-1:0] unit_idx;
        unit_idx = '0;
        for (int b = 0; b < fpa_pkg::WORD_W; b++) begin
            unit_idx  = LW'({i_word, fpa_pkg::WORD_SHIFT'(b)});
            o_mask[b] = (unit_idx >= i_lo) && (unit_idx < i_hi);
        end
    end

endmodule

/* rtl/fpa_hole_scan.sv */
// ============================================================================
// fpa_hole_scan
// Hole search unit. Walks the unit map eight units per step, tracks the start
// of the current free run and keeps the hole chosen so far under the fit mode.
// A close step ends the run that reaches the top of the map.
// ============================================================================
module fpa_hole_scan #(
    parameter int UNIT_COUNT = 1024,
    parameter int LW         = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fpa_pkg::t_scan_ctrl         i_ctrl,
    input  logic [fpa_pkg::MODE_W-1:0]  i_mode,
    input  logic [LW-1:0]               i_need,
    input  logic [LW-1:0]               i_base,
    input  logic [fpa_pkg::CHUNK_W-1:0] i_chunk,
    output logic                        o_found,
    output logic [LW-1:0]               o_best_pos
);

    logic [LW-1:0] r_run_start, n_run_start;
    logic          r_found,     n_found;
    logic [LW-1:0] r_best_pos,  n_best_pos;
    logic [LW-1:0] r_best_len,  n_best_len;

    // Decides whether a fitting hole replaces the one chosen so far.
    function automatic logic better_hole(
        input logic [fpa_pkg::MODE_W-1:0] mode,
        input logic                       found,
        input logic [LW-1:0]              len,
        input logic [LW-1:0]              best_len
    );
        logic take;
        case (mode)
            fpa_pkg::FIT_BEST:  take = !found || (len < best_len);
            fpa_pkg::FIT_WORST: take = !found || (len >= best_len);
            default:            take = !found;
        endcase
        return take;
    endfunction

    // One step: every used unit in the chunk ends the free run before it.
    always_comb begin
        logic [LW-1:0] rs;
        logic [LW-1:0] pos;
        logic [LW-1:0] len;
        logic          used;
        logic          found;
        logic [LW-1:0] bp;
        logic [LW-1:0] bl;

        rs    = r_run_start;
        found = r_found;
        bp    = r_best_pos;
        bl    = r_best_len;
        pos   = '0;
        len   = '0;
        used  = 1'b0;

        if (i_ctrl.start) begin
            rs    = '0;
            found = 1'b0;
            bp    = '0;
            bl    = '0;
        end

        for (int j = 0; j < fpa_pkg::CHUNK_W; j++) begin
            pos  = i_base + LW'(j);
            used = i_chunk[j] || (pos >= LW'(UNIT_COUNT));
            if (i_ctrl.step && used) begin
                len = pos - rs;
                if ((len >= i_need) && better_hole(i_mode, found, len, bl)) begin
                    found = 1'b1;
                    bp    = rs;
                    bl    = len;
                end
                rs = pos + LW'(1);
            end
        end

        // The top of the map ends whatever run is still open.
        if (i_ctrl.close) begin
            pos = LW'(UNIT_COUNT);
            len = pos - rs;
            if ((rs <= pos) && (len >= i_need) && better_hole(i_mode, found, len, bl)) begin
                found = 1'b1;
                bp    = rs;
                bl    = len;
            end
        end

        n_run_start = rs;
        n_found     = found;
        n_best_pos  = bp;
        n_best_len  = bl;
    end

    // Found flag is control state; the rest is datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_start <= n_run_start;
        r_best_pos  <= n_best_pos;
        r_best_len  <= n_best_len;
    end

    assign o_found    = r_found;
    assign o_best_pos = r_best_pos;

endmodule

/* rtl/fit_policy_unit_allocator.sv */
// ============================================================================
// fit_policy_unit_allocator
// Allocation-unit allocator with first, best and worst fit over a used/free
// unit map held in a word-wide RAM.
// ============================================================================
// The block takes one request at a time and returns one response for each.
// After reset it clears the unit map one RAM word at a time and takes no
// request until that is done; configuration writes are taken throughout.
// An allocate walks the whole map through the hole search unit at eight
// units a cycle, then marks the map words that the allocated run touches;
// an allocate of zero units skips the scan. A release reads the words of
// its run once to check that every unit is in use and once more to clear
// them, but only once when a free unit turns up; an out-of-range release
// skips the map. The single read port of the map RAM and the eight-unit
// scan step set the pace of this work. The response waits in an output
// register, so the next request is taken while an earlier response has
// not been collected.
// ============================================================================
module fit_policy_unit_allocator #(
    parameter int UNIT_COUNT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpa_req_if.sink     i_req,
    fpa_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WORDS = (UNIT_COUNT + fpa_pkg::WORD_W - 1) / fpa_pkg::WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = $clog2(UNIT_COUNT + 1);
    localparam int LW    = ((PW > fpa_pkg::SIZE_W) ? PW : fpa_pkg::SIZE_W) + 1;
    localparam int WS    = fpa_pkg::WORD_SHIFT;
    localparam logic [AW-1:0] WORD_LAST = AW'(WORDS - 1);
    localparam logic [fpa_pkg::CHUNK_IDX_W-1:0] CHUNK_LAST = '1;

    // Controller state and datapath registers.
    fpa_pkg::t_state r_state, n_state;
    logic [AW-1:0]                     r_word,       n_word;
    logic [fpa_pkg::CHUNK_IDX_W-1:0]   r_chunk,      n_chunk;
    logic [LW-1:0]                     r_lo,         n_lo;
    logic [LW-1:0]                     r_hi,         n_hi;
    logic [LW-1:0]                     r_need,       n_need;
    logic                              r_set,        n_set;
    logic                              r_ok,         n_ok;
    logic [fpa_pkg::STAT_W-1:0]        r_res_status, n_res_status;
    logic [fpa_pkg::POS_W-1:0]         r_res_pos,    n_res_pos;
    logic                              r_out_valid,  n_out_valid;
    logic [fpa_pkg::STAT_W-1:0]        r_out_status, n_out_status;
    logic [fpa_pkg::POS_W-1:0]         r_out_pos,    n_out_pos;
    logic [fpa_pkg::MODE_W-1:0]        r_fit_mode;

    // RAM and helper signals.
    logic                        ram_wr_en;
    logic [AW-1:0]               ram_wr_addr;
    logic [fpa_pkg::WORD_W-1:0]  ram_wr_data;
    logic                        ram_rd_en;
    logic [AW-1:0]               ram_rd_addr;
    logic [fpa_pkg::WORD_W-1:0]  ram_q;
    logic [fpa_pkg::WORD_W-1:0]  run_mask;
    logic [fpa_pkg::CHUNK_W-1:0] scan_chunk;
    logic [LW-1:0]               scan_base;
    fpa_pkg::t_scan_ctrl         scan_ctrl;
    logic                        scan_found;
    logic [LW-1:0]               scan_best_pos;

    logic          req_accept;
    logic [LW-1:0] req_size;
    logic [LW-1:0] req_pos;
    logic [LW-1:0] req_end;
    logic          req_bad_range;
    logic [LW-1:0] hi_last;
    logic [AW-1:0] lo_word;
    logic [AW-1:0] last_word;
    logic          word_is_last;
    logic          word_has_free;
    logic          out_free;

    // Unit map storage.
    fpa_ram #(
        .WIDTH (fpa_pkg::WORD_W),
        .DEPTH (WORDS)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_q)
    );

    // Hole search over the map words as they come out of the RAM.
    fpa_hole_scan #(
        .UNIT_COUNT (UNIT_COUNT),
        .LW         (LW)
    ) u_hole_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (scan_ctrl),
        .i_mode     (r_fit_mode),
        .i_need     (r_need),
        .i_base     (scan_base),
        .i_chunk    (scan_chunk),
        .o_found    (scan_found),
        .o_best_pos (scan_best_pos)
    );

    // Mask of the current run within the current word.
    fpa_run_mask #(
        .LW (LW),
        .AW (AW)
    ) u_run_mask (
        .i_lo   (r_lo),
        .i_hi   (r_hi),
        .i_word (r_word),
        .o_mask (run_mask)
    );

    // Request decode and range checks.
    assign i_req.ready   = (r_state == fpa_pkg::S_IDLE);
    assign req_accept    = i_req.valid && i_req.ready;
    assign req_size      = LW'(i_req.size_units);
    assign req_pos       = LW'(i_req.release_position);
    assign req_end       = req_pos + req_size;
    assign req_bad_range = (req_size == '0) || (req_end > LW'(UNIT_COUNT));

    // Word bookkeeping for the run being checked or written.
    assign hi_last       = r_hi - LW'(1);
    assign lo_word       = r_lo[AW+WS-1:WS];
    assign last_word     = hi_last[AW+WS-1:WS];
    assign word_is_last  = (r_word == last_word);
    assign word_has_free = |(~ram_q & run_mask);
    assign out_free      = !r_out_valid || o_rsp.ready;

    // Chunk of the current word handed to the hole search.
    assign scan_chunk = ram_q[{r_chunk, fpa_pkg::CHUNK_SHIFT'(0)} +: fpa_pkg::CHUNK_W];
    assign scan_base  = LW'({r_word, r_chunk, fpa_pkg::CHUNK_SHIFT'(0)});

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            fpa_pkg::S_CLEAR: begin
                if (r_word == WORD_LAST) begin
                    n_state = fpa_pkg::S_IDLE;
                end
            end
            fpa_pkg::S_IDLE: begin
                if (req_accept) begin
                    if (i_req.operation == fpa_pkg::OP_ALLOC) begin
                        n_state = (req_size == '0) ? fpa_pkg::S_DONE : fpa_pkg::S_SCAN;
                    end else begin
                        n_state = req_bad_range ? fpa_pkg::S_DONE : fpa_pkg::S_CHECK;
                    end
                end
            end
            fpa_pkg::S_SCAN: begin
                if ((r_chunk == CHUNK_LAST) && (r_word == WORD_LAST)) begin
                    n_state = fpa_pkg::S_CLOSE;
                end
            end
            fpa_pkg::S_CLOSE: begin
                n_state = fpa_pkg::S_PICK;
            end
            fpa_pkg::S_PICK: begin
                n_state = scan_found ? fpa_pkg::S_WRITE : fpa_pkg::S_DONE;
            end
            fpa_pkg::S_CHECK: begin
                if (word_is_last) begin
                    n_state = (!r_ok || word_has_free) ? fpa_pkg::S_DONE : fpa_pkg::S_WRITE;
                end
            end
            fpa_pkg::S_WRITE: begin
                if (word_is_last) begin
                    n_state = fpa_pkg::S_DONE;
                end
            end
            fpa_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = fpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fpa_pkg::S_IDLE;
            end
        endcase
    end

    // Output and datapath logic of the controller.
    always_comb begin
        n_word       = r_word;
        n_chunk      = r_chunk;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_need       = r_need;
        n_set        = r_set;
        n_ok         = r_ok;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_word;
        ram_wr_data  = r_set ? (ram_q | run_mask) : (ram_q & ~run_mask);
        ram_rd_en    = 1'b0;
        ram_rd_addr  = AW'(r_word + AW'(1));
        scan_ctrl    = '0;

        case (r_state)
            // Zero the map word by word after reset.
            fpa_pkg::S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = '0;
                n_word      = (r_word == WORD_LAST) ? '0 : AW'(r_word + AW'(1));
            end
            // Take a request: start the scan, start the release check, or answer at once.
            fpa_pkg::S_IDLE: begin
                if (req_accept) begin
                    n_need = req_size;
                    n_set  = (i_req.operation == fpa_pkg::OP_ALLOC);
                    if (i_req.operation == fpa_pkg::OP_ALLOC) begin
                        n_res_pos = '0;
                        if (req_size == '0) begin
                            n_res_status = fpa_pkg::ST_RANGE;
                        end else begin
                            ram_rd_en       = 1'b1;
                            ram_rd_addr     = '0;
                            n_word          = '0;
                            n_chunk         = '0;
                            scan_ctrl.start = 1'b1;
                        end
                    end else begin
                        n_res_pos = i_req.release_position;
                        if (req_bad_range) begin
                            n_res_status = fpa_pkg::ST_RANGE;
                        end else begin
                            n_lo        = req_pos;
                            n_hi        = req_end;
                            n_ok        = 1'b1;
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = req_pos[AW+WS-1:WS];
                            n_word      = req_pos[AW+WS-1:WS];
                        end
                    end
                end
            end
            // Feed one chunk a cycle; fetch the next word with the last chunk.
            fpa_pkg::S_SCAN: begin
                scan_ctrl.step = 1'b1;
                n_chunk        = r_chunk + fpa_pkg::CHUNK_IDX_W'(1);
                if ((r_chunk == CHUNK_LAST) && (r_word != WORD_LAST)) begin
                    ram_rd_en = 1'b1;
                    n_word    = AW'(r_word + AW'(1));
                end
            end
            fpa_pkg::S_CLOSE: begin
                scan_ctrl.close = 1'b1;
            end
            // Take the chosen hole and start marking its first units, or answer no fit.
            fpa_pkg::S_PICK: begin
                if (scan_found) begin
                    n_lo         = scan_best_pos;
                    n_hi         = scan_best_pos + r_need;
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = scan_best_pos[AW+WS-1:WS];
                    n_word       = scan_best_pos[AW+WS-1:WS];
                    n_res_status = fpa_pkg::ST_OK;
                    n_res_pos    = scan_best_pos[fpa_pkg::POS_W-1:0];
                end else begin
                    n_res_status = fpa_pkg::ST_NOFIT;
                    n_res_pos    = '0;
                end
            end
            // Release check: every unit of the run must be in use.
            fpa_pkg::S_CHECK: begin
                n_ok = r_ok && !word_has_free;
                if (word_is_last) begin
                    if (!r_ok || word_has_free) begin
                        n_res_status = fpa_pkg::ST_FREE;
                    end else begin
                        n_res_status = fpa_pkg::ST_OK;
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = lo_word;
                        n_word       = lo_word;
                    end
                end else begin
                    ram_rd_en = 1'b1;
                    n_word    = AW'(r_word + AW'(1));
                end
            end
            // Read-modify-write: write word w while reading word w+1.
            fpa_pkg::S_WRITE: begin
                ram_wr_en = 1'b1;
                if (!word_is_last) begin
                    ram_rd_en = 1'b1;
                    n_word    = AW'(r_word + AW'(1));
                end
            end
            // Hand the response to the output register once it is free.
            fpa_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_pos    = r_res_pos;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpa_pkg::S_CLEAR;
            r_word      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word      <= n_word;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_chunk      <= n_chunk;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_need       <= n_need;
        r_set        <= n_set;
        r_ok         <= n_ok;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
    end

    // Configuration register: fit mode at byte address 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= fpa_pkg::FIT_FIRST;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_fit_mode <= pwdata[fpa_pkg::MODE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32 - fpa_pkg::MODE_W){1'b0}}, r_fit_mode};

    // Response channel.
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.position = r_out_pos;

endmodule
